FILE: hw/rtl/gtfat_pkg.sv
// Package for the GTF attribute tokenizer.
// Holds the lexer codes, character constants and the structs shared by the modules.
// Depends on nothing.
package gtfat_pkg;

  localparam int unsigned PosW = 16;

  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  typedef enum logic [2:0] {
    MODE_WAIT_KEY,
    MODE_EXT_KEY,
    MODE_WAIT_VALUE,
    MODE_EXT_VALUE,
    MODE_AFTER_QUOTE
  } mode_e;

  typedef enum logic [1:0] {
    QK_NONE,
    QK_SINGLE,
    QK_DOUBLE
  } quote_e;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_QUOTE_IN_KEY,
    ERR_JUNK_AFTER_QUOTE,
    ERR_MISSING_VALUE,
    ERR_UNCLOSED_QUOTE
  } err_e;

  typedef enum logic [1:0] {
    ROLE_SEP,
    ROLE_KEY,
    ROLE_VALUE
  } role_e;

  typedef struct packed {
    mode_e  mode;
    quote_e quote;
    err_e   err;
  } lex_state_t;

  typedef struct packed {
    role_e role;
    logic  done;
    logic  is_key;
  } lex_out_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_term(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_SEMI);
  endfunction

  function automatic quote_e quote_of(input logic [7:0] c);
    quote_e q;
    q = QK_NONE;
    if (c == CH_SQUOTE) q = QK_SINGLE;
    if (c == CH_DQUOTE) q = QK_DOUBLE;
    return q;
  endfunction

endpackage

FILE: hw/rtl/gtf_attribute_tokenizer.sv
// GTF attribute tokenizer top level: one byte per word, lexer state and a result register.
// A result is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the output is taken; the result register frees each cycle it is taken.
// Reset: lexer, error latch and offset counter clear; no result is held.
// After a word with tlast the lexer state returns to its reset values.
// Depends on gtfat_pkg and gtfat_lex.
module gtf_attribute_tokenizer import gtfat_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [7:0] out_byte, [9:8] char_role, [10] token_done,
                                     // [11] token_is_key, [14:12] error_code,
                                     // [30:15] byte_offset, [31] zero
  output logic        m_axis_tlast
);

  lex_state_t        state_q, state_d, lex_next;
  lex_out_t          lex_out;
  logic [PosW-1:0]   pos_q, pos_d;
  logic              out_valid_q, out_valid_d;
  logic [31:0]       out_data_q, out_data_d;
  logic              out_last_q, out_last_d;
  logic              s_fire;

  gtfat_lex u_lex (
    .byte_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .state_i (state_q),
    .state_o (lex_next),
    .out_o   (lex_out)
  );

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    if (m_axis_tready) out_valid_d = 1'b0;
    if (s_fire) begin
      out_valid_d = 1'b1;
      out_last_d  = s_axis_tlast;
      out_data_d  = {1'b0, pos_q, lex_next.err, lex_out.is_key, lex_out.done,
                     lex_out.role, s_axis_tdata};
      if (s_axis_tlast) begin
        state_d = '{mode: MODE_WAIT_KEY, quote: QK_NONE, err: ERR_NONE};
        pos_d   = '0;
      end else begin
        state_d = lex_next;
        if (pos_q != {PosW{1'b1}}) pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '{mode: MODE_WAIT_KEY, quote: QK_NONE, err: ERR_NONE};
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  a_reset_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_axis_tlast |=> pos_q == '0 && state_q.mode == MODE_WAIT_KEY
                               && state_q.err == ERR_NONE && state_q.quote == QK_NONE)
    else $error("lexer state not cleared after last byte");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && !s_axis_tlast && state_q.err != ERR_NONE |=> state_q.err == $past(state_q.err))
    else $error("error latch changed within a string");

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && !s_axis_tlast && pos_q != {PosW{1'b1}} |=> pos_q == $past(pos_q) + 1'b1)
    else $error("byte offset did not advance");

  a_key_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q[11] |-> out_data_q[10])
    else $error("key flag without completed token");

  a_quote_only_in_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.quote != QK_NONE |-> state_q.mode == MODE_EXT_VALUE)
    else $error("quote open outside a value");

endmodule

FILE: hw/rtl/gtfat_lex.sv
// Lexer step of the GTF attribute tokenizer: next state and byte role for one byte.
// Purely combinational; the caller holds the state registers.
// Depends on gtfat_pkg.
module gtfat_lex import gtfat_pkg::*; (
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  lex_state_t state_i,
  output lex_state_t state_o,
  output lex_out_t   out_o
);

  mode_e  mode_mid;
  quote_e quote_mid;

  always_comb begin
    mode_mid      = state_i.mode;
    quote_mid     = state_i.quote;
    state_o.err   = state_i.err;
    case (state_i.mode)
      MODE_EXT_KEY: begin
        if (is_blank(byte_i)) mode_mid = MODE_WAIT_VALUE;
      end
      MODE_WAIT_VALUE: begin
        if (!is_blank(byte_i)) begin
          mode_mid  = MODE_EXT_VALUE;
          quote_mid = quote_of(byte_i);
        end
      end
      MODE_EXT_VALUE: begin
        if (state_i.quote != QK_NONE) begin
          if (quote_of(byte_i) == state_i.quote) begin
            mode_mid  = MODE_AFTER_QUOTE;
            quote_mid = QK_NONE;
          end
        end else if (is_term(byte_i)) begin
          mode_mid = MODE_WAIT_KEY;
        end
      end
      MODE_AFTER_QUOTE: begin
        if (!is_term(byte_i) && state_o.err == ERR_NONE) state_o.err = ERR_JUNK_AFTER_QUOTE;
        mode_mid = MODE_WAIT_KEY;
      end
      default: begin
        mode_mid = MODE_WAIT_KEY;
        if (!is_term(byte_i)) begin
          if (quote_of(byte_i) != QK_NONE) begin
            if (state_o.err == ERR_NONE) state_o.err = ERR_QUOTE_IN_KEY;
          end else begin
            mode_mid = MODE_EXT_KEY;
          end
        end
      end
    endcase

    if (last_i && state_o.err == ERR_NONE) begin
      if (mode_mid == MODE_EXT_KEY || mode_mid == MODE_WAIT_VALUE) begin
        state_o.err = ERR_MISSING_VALUE;
      end else if (mode_mid == MODE_EXT_VALUE && quote_mid != QK_NONE) begin
        state_o.err = ERR_UNCLOSED_QUOTE;
      end
    end

    state_o.mode  = mode_mid;
    state_o.quote = quote_mid;
  end

  always_comb begin
    out_o.role   = ROLE_SEP;
    out_o.done   = 1'b0;
    out_o.is_key = 1'b0;
    case (state_i.mode)
      MODE_EXT_KEY: begin
        if (is_blank(byte_i)) begin
          out_o.done   = 1'b1;
          out_o.is_key = 1'b1;
        end else begin
          out_o.role = ROLE_KEY;
        end
      end
      MODE_WAIT_VALUE: begin
        if (!is_blank(byte_i) && quote_of(byte_i) == QK_NONE) out_o.role = ROLE_VALUE;
      end
      MODE_EXT_VALUE: begin
        if (state_i.quote != QK_NONE) begin
          if (quote_of(byte_i) == state_i.quote) out_o.done = 1'b1;
          else                                   out_o.role = ROLE_VALUE;
        end else if (is_term(byte_i)) begin
          out_o.done = 1'b1;
        end else begin
          out_o.role = ROLE_VALUE;
        end
      end
      MODE_AFTER_QUOTE: begin
        out_o.role = ROLE_SEP;
      end
      default: begin
        if (!is_term(byte_i) && quote_of(byte_i) == QK_NONE) out_o.role = ROLE_KEY;
      end
    endcase

    if (last_i && mode_mid == MODE_EXT_VALUE && quote_mid == QK_NONE) begin
      out_o.done   = 1'b1;
      out_o.is_key = 1'b0;
    end
  end

endmodule
